// ===== rtl/quarter_wave_sine_tone_generator_unit_assert.svh =====
`ifndef QUARTER_WAVE_SINE_TONE_GENERATOR_UNIT_ASSERT_SVH
`define QUARTER_WAVE_SINE_TONE_GENERATOR_UNIT_ASSERT_SVH

// a at an edge implies b at the same edge
`define QWST_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("qwst: implication failed");

// a at an edge implies b at the next edge
`define QWST_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("qwst: next-cycle check failed");

`endif

// ===== rtl/qwst_pkg.sv =====
package qwst_pkg;

    localparam int SAMPLE_RATE     = 48000;
    localparam int QUARTER_ENTRIES = 256;

    localparam int QUARTER_W = $clog2(QUARTER_ENTRIES);
    localparam int FULL_W    = QUARTER_W + 2;
    localparam int FRAC_W    = 16;
    localparam int PHASE_W   = FULL_W + FRAC_W;
    localparam int FRAMES_W  = 22;
    localparam int SAMPLE_W  = 16;

    localparam int HZ_W  = 15;
    localparam int DUR_W = 16;
    localparam int VOL_W = 7;

    localparam int HZ_MAX    = 24000;
    localparam int HZ_RESET  = 440;
    localparam int VOL_MAX   = 100;
    localparam int VOL_RESET = 100;
    localparam int MS_PER_S  = 1000;
    localparam int AMPL_MAX  = (1 << (SAMPLE_W - 1)) - 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TONE_HZ     = 2'd0,
        REG_DURATION_MS = 2'd1,
        REG_VOLUME_PCT  = 2'd2
    } t_reg_idx;

    localparam longint unsigned FRAMES_MAX = (64'd1 << FRAMES_W) - 64'd1;

    // phase step = floor(hz * 2^PHASE_W / SAMPLE_RATE), by reciprocal
    localparam int STEP_SHIFT = $clog2(longint'(HZ_MAX) * SAMPLE_RATE) + 1;
    localparam longint unsigned STEP_RECIP =
        ((64'd1 << (PHASE_W + STEP_SHIFT)) + SAMPLE_RATE - 1) / SAMPLE_RATE;
    localparam int STEP_RECIP_W = $clog2(STEP_RECIP + 1);
    localparam int STEP_LO_W    = STEP_RECIP_W / 2;
    localparam int STEP_HI_W    = STEP_RECIP_W - STEP_LO_W;
    localparam longint unsigned STEP_RECIP_LO = STEP_RECIP & ((64'd1 << STEP_LO_W) - 64'd1);
    localparam longint unsigned STEP_RECIP_HI = STEP_RECIP >> STEP_LO_W;
    localparam int STEP_PROD_W  = HZ_W + STEP_RECIP_W;
    localparam logic [PHASE_W-1:0] STEP_RESET =
        PHASE_W'((64'(HZ_RESET) << PHASE_W) / SAMPLE_RATE);

    // frames = floor(ms * SAMPLE_RATE / 1000), by reciprocal
    localparam int FR_SHIFT = $clog2(longint'((1 << DUR_W) - 1) * MS_PER_S) + 1;
    localparam longint unsigned FR_RECIP =
        ((64'(SAMPLE_RATE) << FR_SHIFT) + MS_PER_S - 1) / MS_PER_S;
    localparam int FR_RECIP_W = $clog2(FR_RECIP + 1);
    localparam int FR_LO_W    = FR_RECIP_W / 2;
    localparam int FR_HI_W    = FR_RECIP_W - FR_LO_W;
    localparam longint unsigned FR_RECIP_LO = FR_RECIP & ((64'd1 << FR_LO_W) - 64'd1);
    localparam longint unsigned FR_RECIP_HI = FR_RECIP >> FR_LO_W;
    localparam int FR_PROD_W  = DUR_W + FR_RECIP_W;

    // magnitude * pct / 100 = (magnitude * (pct * recip)) >> VOL_SHIFT
    localparam int VOL_SHIFT = $clog2(longint'(AMPL_MAX) * VOL_MAX * VOL_MAX) + 1;
    localparam longint unsigned VOL_RECIP = ((64'd1 << VOL_SHIFT) + VOL_MAX - 1) / VOL_MAX;
    localparam int VOL_K_W  = $clog2(longint'(VOL_MAX) * VOL_RECIP + 1);
    localparam logic [VOL_K_W-1:0] VOL_K_RESET = VOL_K_W'(longint'(VOL_RESET) * VOL_RECIP);
    localparam int MAG_PROD_W = SAMPLE_W + VOL_K_W;

    typedef logic [SAMPLE_W-1:0] t_rom [QUARTER_ENTRIES];

    localparam real PI = 3.14159265358979323846;
    localparam real ROM_ANGLE_STEP = PI / (2.0 * QUARTER_ENTRIES);

    function automatic t_rom f_sine_rom();
        t_rom rom;
        for (int i = 0; i < QUARTER_ENTRIES; i++) begin
            rom[i] = SAMPLE_W'($rtoi($floor(
                AMPL_MAX * $sin(ROM_ANGLE_STEP * i) + 0.5)));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_sine_rom();

    typedef struct packed {
        logic [PHASE_W-1:0]  phase_step;
        logic [FRAMES_W-1:0] frames_load;
        logic [VOL_K_W-1:0]  vol_k;
        logic                busy;
    } t_cfg_bus;

endpackage

// ===== rtl/qwst_if.sv =====
interface qwst_in_if;
    logic valid;
    logic ready;
    logic start_tone;

    modport source (output valid, output start_tone, input ready);
    modport sink   (input valid, input start_tone, output ready);
endinterface

interface qwst_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qwst_pkg::SAMPLE_W-1:0]  left_sample;
    logic signed [qwst_pkg::SAMPLE_W-1:0]  right_sample;
    logic                                  last_of_tone;

    modport source (output valid, output left_sample, output right_sample,
                    output last_of_tone, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input last_of_tone, output ready);
endinterface

interface qwst_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qwst_pkg::CFG_IDX_W-1:0]   index;
    logic [qwst_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/quarter_wave_sine_tone_generator_unit.sv =====
// channel  | dir | payload                                  | word moves when
// ---------+-----+------------------------------------------+------------------
// i_in     | in  | start_tone                               | valid && ready
// o_out    | out | left_sample, right_sample, last_of_tone  | valid && ready
// i_cfg    | in  | index, data                              | valid && ready
//
// One input word per cycle while i_in.ready is high; a frame then passes the phase-index
// register, the table/multiply register and the output register.
// Synchronous active-low reset: phase, step and frame count clear, registers
// take their defaults. No clearing pass.
// Stages move independently, so input is taken while a result waits.
// A tone_hz or duration_ms write holds off input while its step/count update is pending.

`include "quarter_wave_sine_tone_generator_unit_assert.svh"

module quarter_wave_sine_tone_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qwst_in_if.sink     i_in,
    qwst_out_if.source  o_out,
    qwst_cfg_if.sink    i_cfg
);

    typedef struct packed {
        logic [qwst_pkg::FULL_W-1:0] idx;
        logic                        last;
    } t_s1;

    typedef struct packed {
        logic [qwst_pkg::MAG_PROD_W-1:0] product;
        logic                            neg;
        logic                            last;
    } t_s2;

    qwst_pkg::t_cfg_bus cfg_bus;

    logic                            in_fire;
    logic                            start;
    logic                            emit;
    logic                            s1_load;
    logic                            s2_load;
    logic                            out_load;
    logic [qwst_pkg::FRAMES_W-1:0]   frames_eff;
    logic [qwst_pkg::PHASE_W-1:0]    phase_eff;
    logic [qwst_pkg::PHASE_W-1:0]    step_eff;
    logic [qwst_pkg::MAG_PROD_W-1:0] w_product;
    logic                            w_neg;
    logic [qwst_pkg::SAMPLE_W-1:0]   mag;

    logic [qwst_pkg::PHASE_W-1:0]    n_phase;
    logic [qwst_pkg::FRAMES_W-1:0]   n_frames;
    logic [qwst_pkg::SAMPLE_W-1:0]   n_sample;

    logic [qwst_pkg::PHASE_W-1:0]    r_phase;
    logic [qwst_pkg::PHASE_W-1:0]    r_step;
    logic [qwst_pkg::FRAMES_W-1:0]   r_frames;
    logic                            r_s1_valid;
    t_s1                             r_s1;
    logic                            r_s2_valid;
    t_s2                             r_s2;
    logic                            r_out_valid;
    logic [qwst_pkg::SAMPLE_W-1:0]   r_out_sample;
    logic                            r_out_last;

    qwst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg_bus)
    );

    qwst_wave u_wave (
        .i_idx     (r_s1.idx),
        .i_vol_k   (cfg_bus.vol_k),
        .o_product (w_product),
        .o_neg     (w_neg)
    );

    assign out_load   = !r_out_valid || o_out.ready;
    assign s2_load    = !r_s2_valid || out_load;
    assign s1_load    = !r_s1_valid || s2_load;
    assign i_in.ready = s1_load && !cfg_bus.busy;
    assign in_fire    = i_in.valid && i_in.ready;

    assign start      = i_in.start_tone;
    assign frames_eff = start ? cfg_bus.frames_load : r_frames;
    assign phase_eff  = start ? '0 : r_phase;
    assign step_eff   = start ? cfg_bus.phase_step : r_step;
    assign emit       = (frames_eff != '0);
    assign n_phase    = emit ? phase_eff + step_eff : phase_eff;
    assign n_frames   = emit ? frames_eff - qwst_pkg::FRAMES_W'(1) : frames_eff;

    assign mag      = qwst_pkg::SAMPLE_W'(r_s2.product >> qwst_pkg::VOL_SHIFT);
    assign n_sample = r_s2.neg ? -mag : mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_frames    <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase  <= n_phase;
                r_frames <= n_frames;
                if (start) begin
                    r_step <= cfg_bus.phase_step;
                end
            end
            if (s1_load) begin
                r_s1_valid <= in_fire && emit;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_load) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1.idx  <= phase_eff[qwst_pkg::PHASE_W-1 -: qwst_pkg::FULL_W];
            r_s1.last <= (frames_eff == qwst_pkg::FRAMES_W'(1));
        end
        if (s2_load) begin
            r_s2.product <= w_product;
            r_s2.neg     <= w_neg;
            r_s2.last    <= r_s1.last;
        end
        if (out_load) begin
            r_out_sample <= n_sample;
            r_out_last   <= r_s2.last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.left_sample  = r_out_sample;
    assign o_out.right_sample = r_out_sample;
    assign o_out.last_of_tone = r_out_last;

    `QWST_ASSERT_IMP(a_busy_holds_input, i_clk, i_rst_n, cfg_bus.busy, !i_in.ready)
    `QWST_ASSERT_NEXT(a_last_empties_tone, i_clk, i_rst_n, in_fire && emit && (frames_eff == qwst_pkg::FRAMES_W'(1)), r_frames == '0)
    `QWST_ASSERT_NEXT(a_start_clears_phase, i_clk, i_rst_n, in_fire && start, (r_phase == '0) || (r_phase == r_step))

endmodule

// ===== rtl/qwst_cfg.sv =====
module qwst_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    qwst_cfg_if.sink           i_cfg,
    output qwst_pkg::t_cfg_bus o_cfg
);

    logic                               wr;
    logic                               wr_hz;
    logic                               wr_dur;
    logic                               wr_vol;
    logic [qwst_pkg::HZ_W-1:0]          hz_raw;
    logic [qwst_pkg::HZ_W-1:0]          hz_clamp;
    logic [qwst_pkg::DUR_W-1:0]         dur_raw;
    logic [qwst_pkg::VOL_W-1:0]         vol_raw;
    logic [qwst_pkg::VOL_W-1:0]         vol_clamp;
    logic [qwst_pkg::STEP_PROD_W-1:0]   step_sum;
    logic [qwst_pkg::STEP_PROD_W-1:0]   step_shifted;
    logic [qwst_pkg::FR_PROD_W-1:0]     frames_sum;
    logic [qwst_pkg::FR_PROD_W-1:0]     frames_n;

    logic [qwst_pkg::HZ_W+qwst_pkg::STEP_LO_W-1:0]  n_hz_prod_lo;
    logic [qwst_pkg::HZ_W+qwst_pkg::STEP_HI_W-1:0]  n_hz_prod_hi;
    logic [qwst_pkg::DUR_W+qwst_pkg::FR_LO_W-1:0]   n_dur_prod_lo;
    logic [qwst_pkg::DUR_W+qwst_pkg::FR_HI_W-1:0]   n_dur_prod_hi;
    logic [qwst_pkg::PHASE_W-1:0]                   n_phase_step;
    logic [qwst_pkg::FRAMES_W-1:0]                  n_frames_load;
    logic [qwst_pkg::VOL_K_W-1:0]                   n_vol_k;

    logic [qwst_pkg::HZ_W+qwst_pkg::STEP_LO_W-1:0]  r_hz_prod_lo;
    logic [qwst_pkg::HZ_W+qwst_pkg::STEP_HI_W-1:0]  r_hz_prod_hi;
    logic [qwst_pkg::DUR_W+qwst_pkg::FR_LO_W-1:0]   r_dur_prod_lo;
    logic [qwst_pkg::DUR_W+qwst_pkg::FR_HI_W-1:0]   r_dur_prod_hi;
    logic                                           r_hz_pend;
    logic                                           r_dur_pend;
    logic [qwst_pkg::PHASE_W-1:0]                   r_phase_step;
    logic [qwst_pkg::FRAMES_W-1:0]                  r_frames_load;
    logic [qwst_pkg::VOL_K_W-1:0]                   r_vol_k;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid && i_cfg.ready;

    always_comb begin
        wr_hz  = 1'b0;
        wr_dur = 1'b0;
        wr_vol = 1'b0;
        case (qwst_pkg::t_reg_idx'(i_cfg.index))
            qwst_pkg::REG_TONE_HZ:     wr_hz  = wr;
            qwst_pkg::REG_DURATION_MS: wr_dur = wr;
            qwst_pkg::REG_VOLUME_PCT:  wr_vol = wr;
            default: begin
            end
        endcase
    end

    assign hz_raw   = i_cfg.data[qwst_pkg::HZ_W-1:0];
    assign hz_clamp = (hz_raw > qwst_pkg::HZ_W'(qwst_pkg::HZ_MAX)) ?
                      qwst_pkg::HZ_W'(qwst_pkg::HZ_MAX) : hz_raw;
    assign dur_raw  = i_cfg.data[qwst_pkg::DUR_W-1:0];
    assign vol_raw  = i_cfg.data[qwst_pkg::VOL_W-1:0];
    assign vol_clamp = (vol_raw > qwst_pkg::VOL_W'(qwst_pkg::VOL_MAX)) ?
                       qwst_pkg::VOL_W'(qwst_pkg::VOL_MAX) : vol_raw;

    // split reciprocals: two narrow products now, sum next cycle
    assign n_hz_prod_lo =
        (qwst_pkg::HZ_W + qwst_pkg::STEP_LO_W)'(hz_clamp) *
        (qwst_pkg::HZ_W + qwst_pkg::STEP_LO_W)'(qwst_pkg::STEP_RECIP_LO);
    assign n_hz_prod_hi =
        (qwst_pkg::HZ_W + qwst_pkg::STEP_HI_W)'(hz_clamp) *
        (qwst_pkg::HZ_W + qwst_pkg::STEP_HI_W)'(qwst_pkg::STEP_RECIP_HI);
    assign n_dur_prod_lo =
        (qwst_pkg::DUR_W + qwst_pkg::FR_LO_W)'(dur_raw) *
        (qwst_pkg::DUR_W + qwst_pkg::FR_LO_W)'(qwst_pkg::FR_RECIP_LO);
    assign n_dur_prod_hi =
        (qwst_pkg::DUR_W + qwst_pkg::FR_HI_W)'(dur_raw) *
        (qwst_pkg::DUR_W + qwst_pkg::FR_HI_W)'(qwst_pkg::FR_RECIP_HI);
    assign n_vol_k = qwst_pkg::VOL_K_W'(vol_clamp) *
                     qwst_pkg::VOL_K_W'(qwst_pkg::VOL_RECIP);

    assign step_sum = (qwst_pkg::STEP_PROD_W'(r_hz_prod_hi) << qwst_pkg::STEP_LO_W) +
                      qwst_pkg::STEP_PROD_W'(r_hz_prod_lo);
    assign step_shifted = step_sum >> qwst_pkg::STEP_SHIFT;
    assign n_phase_step = qwst_pkg::PHASE_W'(step_shifted);

    assign frames_sum = (qwst_pkg::FR_PROD_W'(r_dur_prod_hi) << qwst_pkg::FR_LO_W) +
                        qwst_pkg::FR_PROD_W'(r_dur_prod_lo);
    assign frames_n = frames_sum >> qwst_pkg::FR_SHIFT;
    assign n_frames_load = (64'(frames_n) > qwst_pkg::FRAMES_MAX) ?
                           qwst_pkg::FRAMES_W'(qwst_pkg::FRAMES_MAX) :
                           qwst_pkg::FRAMES_W'(frames_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz_pend     <= 1'b0;
            r_dur_pend    <= 1'b0;
            r_phase_step  <= qwst_pkg::STEP_RESET;
            r_frames_load <= '0;
            r_vol_k       <= qwst_pkg::VOL_K_RESET;
        end else begin
            r_hz_pend  <= wr_hz;
            r_dur_pend <= wr_dur;
            if (wr_vol) begin
                r_vol_k <= n_vol_k;
            end
            if (r_hz_pend) begin
                r_phase_step <= n_phase_step;
            end
            if (r_dur_pend) begin
                r_frames_load <= n_frames_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hz) begin
            r_hz_prod_lo <= n_hz_prod_lo;
            r_hz_prod_hi <= n_hz_prod_hi;
        end
        if (wr_dur) begin
            r_dur_prod_lo <= n_dur_prod_lo;
            r_dur_prod_hi <= n_dur_prod_hi;
        end
    end

    assign o_cfg.phase_step  = r_phase_step;
    assign o_cfg.frames_load = r_frames_load;
    assign o_cfg.vol_k       = r_vol_k;
    assign o_cfg.busy        = r_hz_pend || r_dur_pend;

endmodule

// ===== rtl/qwst_wave.sv =====
module qwst_wave (
    input  logic [qwst_pkg::FULL_W-1:0]     i_idx,
    input  logic [qwst_pkg::VOL_K_W-1:0]    i_vol_k,
    output logic [qwst_pkg::MAG_PROD_W-1:0] o_product,
    output logic                            o_neg
);

    logic [qwst_pkg::QUARTER_W-1:0] offset;
    logic [qwst_pkg::QUARTER_W-1:0] rom_addr;
    logic [qwst_pkg::SAMPLE_W-1:0]  rom_val;

    // second and fourth quarters run the table backwards, second half negates
    assign offset   = i_idx[qwst_pkg::QUARTER_W-1:0];
    assign rom_addr = i_idx[qwst_pkg::QUARTER_W] ? ~offset : offset;
    assign rom_val  = qwst_pkg::SINE_ROM[rom_addr];
    assign o_neg    = i_idx[qwst_pkg::FULL_W-1];

    assign o_product = qwst_pkg::MAG_PROD_W'(rom_val) *
                       qwst_pkg::MAG_PROD_W'(i_vol_k);

endmodule

// ===== tb/sv/tb_quarter_wave_sine_tone_generator_unit.sv =====
`timescale 1ns / 100ps

module tb_quarter_wave_sine_tone_generator_unit;
    import qwst_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          ITEM_TARGET    = 1400;
    localparam int          REPORT_CAP     = 100;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;

    typedef enum {ROW_CFG, ROW_ITEM} row_e;
    typedef enum {CHK_MODEL, CHK_SILENT, CHK_FRAME} chk_e;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        bit                         last;
    } tone_frame_t;

    typedef struct {
        row_e                       kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [CFG_DATA_W-1:0]      val;
        bit                         start;
        chk_e                       chk;
        logic signed [SAMPLE_W-1:0] lit;
        bit                         lit_last;
    } script_row_t;

    localparam int SCRIPT_LEN = 37;

    // silence checks: zero duration, zero volume, zero tone, 24 kHz clamp (phase only hits 0 and 512)
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_SILENT, 16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_SILENT, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_DURATION_MS, 16'd1,    1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_DURATION_MS, 16'd0,    1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_SILENT, 16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_SILENT, 16'sd0, 1'b0},
        '{ROW_CFG,  REG_VOLUME_PCT,  16'h007F, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_TONE_HZ,     16'h7FFF, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_DURATION_MS, 16'd1,    1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_TONE_HZ,     16'd12000, 1'b0, CHK_MODEL, 16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_VOLUME_PCT,  16'd0,    1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_UNUSED,      16'hFFFF, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_VOLUME_PCT,  16'd100,  1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_TONE_HZ,     16'd0,    1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_TONE_HZ,     16'h8001, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_CFG,  REG_DURATION_MS, 16'hFFFF, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b1, CHK_FRAME,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0},
        '{ROW_ITEM, REG_TONE_HZ,     16'h0000, 1'b0, CHK_MODEL,  16'sd0, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    qwst_in_if  in_ch ();
    qwst_out_if out_ch ();
    qwst_cfg_if cfg_ch ();

    quarter_wave_sine_tone_generator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // tone state as the block should hold it
    int                  quarter_rom [QUARTER_ENTRIES];
    int unsigned         hz_reg     = HZ_RESET;
    int unsigned         ms_reg     = 0;
    int unsigned         vol_reg    = VOL_RESET;
    logic [PHASE_W-1:0]  phase_acc  = '0;
    logic [PHASE_W-1:0]  phase_inc  = '0;
    logic [FRAMES_W-1:0] frames_rem = '0;

    tone_frame_t pending_frames [$];

    chk_e                       offer_chk  = CHK_MODEL;
    logic signed [SAMPLE_W-1:0] offer_lit  = '0;
    bit                         offer_last = 1'b0;

    int  fault_count   = 0;
    int  frames_seen   = 0;
    int  tone_starts   = 0;
    int  reg_writes    = 0;
    int  items_sent    = 0;
    int  phase_count   = 0;
    int  idle_cycles   = 0;
    int  burst_left    = 0;
    bit  no_gaps       = 1'b0;
    bit  hold_off_req  = 1'b0;
    bit  hold_off_done = 1'b0;

    function automatic void synth_frame(input bit start, output bit emit,
                                        output tone_frame_t fr);
        longint unsigned         n;
        logic [FULL_W-1:0]       idx;
        logic [QUARTER_W-1:0]    ofs;
        int                      s;
        int unsigned             mag;
        emit      = 1'b0;
        fr.sample = '0;
        fr.last   = 1'b0;
        if (start) begin
            n          = longint'(SAMPLE_RATE) * ms_reg / MS_PER_S;
            frames_rem = (n > FRAMES_MAX) ? FRAMES_W'(FRAMES_MAX) : FRAMES_W'(n);
            phase_inc  = PHASE_W'((longint'(hz_reg) << PHASE_W) / SAMPLE_RATE);
            phase_acc  = '0;
        end
        if (frames_rem == 0) return;
        idx = phase_acc[PHASE_W-1 -: FULL_W];
        ofs = idx[QUARTER_W-1:0];
        case (idx[FULL_W-1 -: 2])
            2'd0: s =  quarter_rom[ofs];
            2'd1: s =  quarter_rom[QUARTER_ENTRIES - 1 - ofs];
            2'd2: s = -quarter_rom[ofs];
            default: s = -quarter_rom[QUARTER_ENTRIES - 1 - ofs];
        endcase
        mag       = ((s < 0) ? -s : s) * vol_reg / VOL_MAX;
        fr.sample = (s < 0) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
        phase_acc  = phase_acc + phase_inc;
        frames_rem = frames_rem - 1'b1;
        fr.last    = (frames_rem == 0);
        emit       = 1'b1;
    endfunction

    task automatic report(input string what, input longint want, input longint got);
        fault_count++;
        if (fault_count <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic check_frame();
        tone_frame_t want;
        frames_seen++;
        if (pending_frames.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
                $display("%0t ns: unexpected frame, expected none, got %0d last %0b",
                         $time, out_ch.left_sample, out_ch.last_of_tone);
            return;
        end
        want = pending_frames.pop_front();
        if (out_ch.left_sample !== want.sample)
            report("left_sample", want.sample, out_ch.left_sample);
        if (out_ch.right_sample !== want.sample)
            report("right_sample", want.sample, out_ch.right_sample);
        if (out_ch.last_of_tone !== want.last)
            report("last_of_tone", want.last, out_ch.last_of_tone);
    endtask

    task automatic take_item();
        bit          emit;
        tone_frame_t fr;
        items_sent++;
        if (in_ch.start_tone) tone_starts++;
        synth_frame(in_ch.start_tone, emit, fr);
        case (offer_chk)
            CHK_SILENT: ;
            CHK_FRAME: begin
                fr.sample = offer_lit;
                fr.last   = offer_last;
                pending_frames.push_back(fr);
            end
            default: if (emit) pending_frames.push_back(fr);
        endcase
    endtask

    task automatic take_reg_write();
        reg_writes++;
        case (cfg_ch.index)
            REG_TONE_HZ:     hz_reg  = (cfg_ch.data[HZ_W-1:0] > HZ_MAX) ?
                                       HZ_MAX : cfg_ch.data[HZ_W-1:0];
            REG_DURATION_MS: ms_reg  = cfg_ch.data[DUR_W-1:0];
            REG_VOLUME_PCT:  vol_reg = (cfg_ch.data[VOL_W-1:0] > VOL_MAX) ?
                                       VOL_MAX : cfg_ch.data[VOL_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) check_frame();
            if (cfg_ch.valid && cfg_ch.ready) take_reg_write();
            if (in_ch.valid && in_ch.ready) take_item();
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles, %0d frames outstanding",
                         $time, WATCHDOG_LIMIT, pending_frames.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        int tick;
        out_ch.ready = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 200);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                if (hold_off_req && !hold_off_done) begin
                    hold_off_done = 1'b1;
                    out_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    2: out_ch.ready <= (tick % 4 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (no_gaps) gap = 0;
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
        end
        burst_left--;
    endtask

    task automatic offer_word(input bit start, input chk_e chk,
                              input logic signed [SAMPLE_W-1:0] lit, input bit lit_last);
        pace();
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.start_tone <= start;
        offer_chk        <= chk;
        offer_lit        <= lit;
        offer_last       <= lit_last;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_hz();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 20) return CFG_DATA_W'(HZ_MAX);
        if (r < 35) return CFG_DATA_W'($urandom());
        return CFG_DATA_W'($urandom_range(1, HZ_MAX));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 70) return CFG_DATA_W'($urandom_range(1, 3));
        if (r < 85) return CFG_DATA_W'($urandom_range(4, 40));
        if (r < 92) return 16'hFFFF;
        return CFG_DATA_W'($urandom());
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_vol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 25) return CFG_DATA_W'(VOL_MAX);
        if (r < 40) return CFG_DATA_W'($urandom());
        return CFG_DATA_W'($urandom_range(1, VOL_MAX));
    endfunction

    task automatic run_phase(input int n_items, input bit open_with_start);
        bit start;
        for (int k = 0; k < n_items && items_sent < ITEM_TARGET; k++) begin
            if (k == 0) start = open_with_start;
            else if (frames_rem == 0) start = $urandom_range(0, 1);
            else start = ($urandom_range(0, 39) == 0);
            offer_word(start, CHK_MODEL, '0, 1'b0);
        end
    endtask

    initial begin
        bit first;
        for (int i = 0; i < QUARTER_ENTRIES; i++)
            quarter_rom[i] = $rtoi($floor(AMPL_MAX *
                             $sin(3.14159265358979323846 * i / (2.0 * QUARTER_ENTRIES)) + 0.5));
        in_ch.valid      = 1'b0;
        in_ch.start_tone = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (script[r].kind == ROW_CFG) begin
                settle();
                write_reg(script[r].reg_idx, script[r].val);
            end else begin
                offer_word(script[r].start, script[r].chk, script[r].lit,
                           script[r].lit_last);
            end
        end

        first = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            settle();
            phase_count++;
            if (phase_count == 4) begin
                // long tone, receiver holds off while words keep coming
                write_reg(REG_DURATION_MS, 16'hFFFF);
                write_reg(REG_VOLUME_PCT, pick_vol());
                @(negedge i_clk);
                hold_off_req <= 1'b1;
                no_gaps = 1'b1;
                run_phase(160, 1'b1);
                no_gaps = 1'b0;
            end else begin
                if (first || $urandom_range(0, 3) != 0) write_reg(REG_TONE_HZ, pick_hz());
                if (first || $urandom_range(0, 3) != 0) write_reg(REG_DURATION_MS, pick_ms());
                if (first || $urandom_range(0, 3) != 0) write_reg(REG_VOLUME_PCT, pick_vol());
                if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
                first = 1'b0;
                run_phase($urandom_range(40, 160), $urandom_range(0, 99) < 85);
            end
        end

        settle();
        $display("Checked %0d frames from %0d tone starts over %0d phases, %0d register writes",
                 frames_seen, tone_starts, phase_count, reg_writes);
        $display("Included one %0d-cycle receiver hold-off with input back-pressure",
                 HOLD_CYCLES);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
